[hw/rtl/dcp_pkg.sv]
// ----------------------------------------------------------------------------
// dcp_pkg
// Shared types, constants and the prefix table of the downlink command parser.
// ----------------------------------------------------------------------------
package dcp_pkg;

  localparam int unsigned PrefixLen = 12;
  localparam int unsigned PosW      = 4;
  localparam int unsigned AccW      = 19;
  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  localparam logic [15:0] IntervalLimitRst = 16'd1440;
  localparam logic [17:0] SleepLimitRst    = 18'd259200;
  localparam logic [15:0] SleepIntervalRst = 16'd600;

  localparam int unsigned CfgDataW  = 18;
  localparam int unsigned CfgIndexW = 2;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_INTERVAL_LIMIT = 2'd0,
    CFG_SLEEP_LIMIT    = 2'd1,
    CFG_SLEEP_INTERVAL = 2'd2
  } dcp_cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_INTERVAL = 2'd1,
    KIND_SLEEP    = 2'd2
  } dcp_kind_e;

  // One-hot parse phase
  typedef enum logic [5:0] {
    PH_PREFIX = 6'b000001,
    PH_SPACE  = 6'b000010,
    PH_SIGN   = 6'b000100,
    PH_DIGITS = 6'b001000,
    PH_DONE   = 6'b010000,
    PH_REJECT = 6'b100000
  } dcp_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } dcp_in_t;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  command_kind;
    logic [21:0] new_interval_seconds;
    logic [17:0] new_sleep_seconds;
  } dcp_out_t;

  typedef struct packed {
    logic [15:0] interval_limit_minutes;
    logic [17:0] sleep_limit_seconds;
    logic [15:0] sleep_command_interval;
  } dcp_cfg_t;

  // Common part of both prefixes "+DATA:PK00?,"; position 10 differs.
  function automatic logic [7:0] prefix_char(input logic [PosW-1:0] pos, input logic second);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h2B; // '+'
      4'd1:    ch = 8'h44; // 'D'
      4'd2:    ch = 8'h41; // 'A'
      4'd3:    ch = 8'h54; // 'T'
      4'd4:    ch = 8'h41; // 'A'
      4'd5:    ch = 8'h3A; // ':'
      4'd6:    ch = 8'h50; // 'P'
      4'd7:    ch = 8'h4B; // 'K'
      4'd8:    ch = 8'h30; // '0'
      4'd9:    ch = 8'h30; // '0'
      4'd10:   ch = second ? 8'h37 : 8'h36;
      4'd11:   ch = 8'h2C; // ','
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/dcp_char_step.sv]
// ----------------------------------------------------------------------------
// dcp_char_step
// Per-character parser state and the verdict computed on the final byte.
// ----------------------------------------------------------------------------
module dcp_char_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  dcp_pkg::dcp_in_t  item_i,
  input  dcp_pkg::dcp_cfg_t cfg_i,
  output dcp_pkg::dcp_out_t verdict_o
);
  import dcp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      match_q, match_d;
  dcp_phase_e      phase_q, phase_d;
  logic            neg_q, neg_d;
  logic            seen_q, seen_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            ended_q, ended_d;

  logic [7:0]      ch;
  logic            is_digit;
  logic            is_space;
  logic            is_sign;
  logic [AccW+3:0] acc_x10;
  logic [AccW-1:0] acc_next;
  logic            ok;
  logic [21:0]     ivl_x60;

  assign ch       = item_i.data_byte;
  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_space = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
  assign is_sign  = (ch == 8'h2B) || (ch == 8'h2D);
  assign acc_x10  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {19'd0, ch[3:0]};
  assign acc_next = (acc_x10 > {4'd0, AccMax}) ? AccMax : acc_x10[AccW-1:0];

  // Next parser state from the current character
  always_comb begin
    pos_d   = pos_q;
    match_d = match_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    acc_d   = acc_q;
    ended_d = ended_q;
    if (!ended_q) begin
      if (ch == 8'h00) begin
        ended_d = 1'b1;
      end else begin
        unique case (phase_q)
          PH_PREFIX: begin
            if (ch != prefix_char(pos_q, 1'b0)) match_d[0] = 1'b0;
            if (ch != prefix_char(pos_q, 1'b1)) match_d[1] = 1'b0;
            pos_d = pos_q + 1'b1;
            if (pos_d >= PosW'(PrefixLen)) begin
              phase_d = (match_d != 2'b00) ? PH_SPACE : PH_REJECT;
            end
          end
          PH_SPACE, PH_SIGN, PH_DIGITS: begin
            if (phase_q == PH_SPACE && is_space) begin
              phase_d = PH_SPACE;
            end else if (phase_q == PH_SPACE && is_sign) begin
              neg_d   = (ch == 8'h2D);
              phase_d = PH_SIGN;
            end else if (is_digit) begin
              acc_d   = acc_next;
              seen_d  = 1'b1;
              phase_d = PH_DIGITS;
            end else begin
              phase_d = (phase_q == PH_DIGITS) ? PH_DONE : PH_REJECT;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Verdict from the state after this character
  assign ok = ((phase_d == PH_DIGITS) || (phase_d == PH_DONE)) && seen_d &&
              !(neg_d && (acc_d != '0));
  assign ivl_x60 = {acc_d[15:0], 6'd0} - {4'd0, acc_d[15:0], 2'd0};

  always_comb begin
    verdict_o = '0;
    if (ok) begin
      if (match_d[0]) begin
        if (acc_d <= {3'd0, cfg_i.interval_limit_minutes}) begin
          verdict_o.accepted             = 1'b1;
          verdict_o.command_kind         = KIND_INTERVAL;
          verdict_o.new_interval_seconds = ivl_x60;
        end
      end else if (match_d[1]) begin
        if (acc_d <= {1'b0, cfg_i.sleep_limit_seconds}) begin
          verdict_o.accepted             = 1'b1;
          verdict_o.command_kind         = KIND_SLEEP;
          verdict_o.new_interval_seconds = {6'd0, cfg_i.sleep_command_interval};
          verdict_o.new_sleep_seconds    = acc_d[17:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 2'b11;
      phase_q <= PH_PREFIX;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= '0;
      ended_q <= 1'b0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        pos_q   <= '0;
        match_q <= 2'b11;
        phase_q <= PH_PREFIX;
        neg_q   <= 1'b0;
        seen_q  <= 1'b0;
        acc_q   <= '0;
        ended_q <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        match_q <= match_d;
        phase_q <= phase_d;
        neg_q   <= neg_d;
        seen_q  <= seen_d;
        acc_q   <= acc_d;
        ended_q <= ended_d;
      end
    end
  end

endmodule

[hw/rtl/dcp_result_buf.sv]
// ----------------------------------------------------------------------------
// dcp_result_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module dcp_result_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dcp_pkg::dcp_out_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dcp_pkg::dcp_out_t out_data_o
);
  import dcp_pkg::*;

  logic     out_valid_q;
  logic     skid_valid_q;
  dcp_out_t out_q;
  dcp_out_t skid_q;
  logic     out_fire;

  assign out_fire    = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // drain skid into the output register
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (out_valid_q && !out_fire) begin
      skid_valid_q <= push_i;
    end else begin
      out_valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (out_valid_q && !out_fire) begin
      if (push_i) skid_q <= push_data_i;
    end else if (push_i) begin
      out_q <= push_data_i;
    end
  end

endmodule

[hw/rtl/downlink_command_parser_unit.sv]
// ----------------------------------------------------------------------------
// downlink_command_parser_unit
// Byte-wide parser for "+DATA:PK006,<min>" and "+DATA:PK007,<sec>" commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character per transfer (data_byte, last_byte) under
//   in_valid_i / in_stall_o. A zero byte ends the text; later bytes up to
//   the one marked last_byte are ignored.
//   Output channel: exactly one verdict per message, produced for the byte
//   marked last_byte, under out_valid_o / out_stall_i.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 interval limit, 1 sleep limit, 2 sleep-command interval); write only
//   while no message is in flight.
// Timing:
//   One byte per cycle sustained while in_stall_o is low. A message's last
//   byte is transferred into the input register; when the result side has
//   room, the parser state updates and the verdict loads into the result
//   register, which drives out_valid_o.
// Reset:
//   Parser state returns to the start of a message, registers take their
//   defaults (1440 min, 259200 s, 600 s) and both channels go empty.
// Stall:
//   A stalled verdict holds in the result register; one more verdict fits
//   in a skid entry, after which in_stall_o rises until the receiver drains.
// ----------------------------------------------------------------------------
module downlink_command_parser_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  dcp_pkg::dcp_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output dcp_pkg::dcp_out_t                   out_data_o,
  input  logic                                cfg_we_i,
  input  logic [dcp_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [dcp_pkg::CfgDataW-1:0]        cfg_data_i
);
  import dcp_pkg::*;

  dcp_cfg_t cfg_q;
  logic     s1_valid_q;
  dcp_in_t  s1_data_q;
  logic     in_fire;
  logic     step;
  logic     buf_full;
  dcp_out_t verdict;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_limit_minutes <= IntervalLimitRst;
      cfg_q.sleep_limit_seconds    <= SleepLimitRst;
      cfg_q.sleep_command_interval <= SleepIntervalRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_INTERVAL_LIMIT: cfg_q.interval_limit_minutes <= cfg_data_i[15:0];
        CFG_SLEEP_LIMIT:    cfg_q.sleep_limit_seconds    <= cfg_data_i;
        CFG_SLEEP_INTERVAL: cfg_q.sleep_command_interval <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input register: advance whenever the result side has room
  assign step       = s1_valid_q && !buf_full;
  assign in_stall_o = s1_valid_q && buf_full;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire || (s1_valid_q && !step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_data_q <= in_data_i;
  end

  dcp_char_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (s1_data_q),
    .cfg_i     (cfg_q),
    .verdict_o (verdict)
  );

  // Only the final byte of a message produces a verdict
  dcp_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && s1_data_q.last_byte),
    .push_data_i (verdict),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
